// ===== sv/hmm_viterbi_decoder_core_defines.svh =====
// Assertion macros used by the decoder checker.
`ifndef HMM_VITERBI_DECODER_CORE_DEFINES_SVH
`define HMM_VITERBI_DECODER_CORE_DEFINES_SVH

// same-cycle implication
`define HVD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HVD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// delayed implication
`define HVD_ASSERT_LATER2(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##2 (cons)) \
		else $error(msg);

`endif

// ===== sv/hvd_pkg.sv =====
// Types, codes and defaults shared by the Viterbi decoder modules.
package hvd_pkg;

	localparam int DEF_MAX_STATES  = 8;
	localparam int DEF_MAX_LEN     = 64;
	localparam int DEF_SCORE_WIDTH = 32;

	localparam logic [3:0] NUM_STATES_RST = 4'd8;

	localparam logic [1:0] MODE_TRANS = 2'd0;
	localparam logic [1:0] MODE_INIT  = 2'd1;
	localparam logic [1:0] MODE_EMIT  = 2'd2;

	typedef struct packed {
		logic [1:0]         mode;
		logic [2:0]         from_state;
		logic [2:0]         to_state;
		logic signed [31:0] value;
		logic               last_obs;
	} in_beat_t;

	typedef struct packed {
		logic [2:0]         path_state;
		logic [5:0]         time_index;
		logic signed [31:0] best_score;
		logic               overflow;
		logic               last;
	} out_beat_t;

	typedef enum logic [1:0] {
		ACU_IDLE,
		ACU_FIRST,
		ACU_CMP
	} acu_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_COL0,
		ST_ACS,
		ST_ACS_END,
		ST_ADDV,
		ST_CLOSE,
		ST_COPY,
		ST_COPY_END,
		ST_ARG,
		ST_ARG_END,
		ST_TB_START,
		ST_EMIT,
		ST_TB_WAIT
	} hvd_state_t;

endpackage

// ===== sv/hvd_acu.sv =====
// Shared saturating add-compare-select unit with running best score and argmax.
module hvd_acu import hvd_pkg::*; #(
	parameter int SCORE_WIDTH = DEF_SCORE_WIDTH,
	parameter int MAX_STATES  = DEF_MAX_STATES,
	localparam int IW = $clog2(MAX_STATES)
) (
	input  logic                          clk,
	input  acu_op_t                       op,
	input  logic [IW-1:0]                 idx,
	input  logic signed [SCORE_WIDTH-1:0] a,
	input  logic signed [SCORE_WIDTH-1:0] b,
	output logic signed [SCORE_WIDTH-1:0] sum,
	output logic signed [SCORE_WIDTH-1:0] best,
	output logic [IW-1:0]                 arg
);

	localparam logic signed [SCORE_WIDTH-1:0] SMIN = {1'b1, {(SCORE_WIDTH-1){1'b0}}};
	localparam logic signed [SCORE_WIDTH-1:0] SMAX = ~SMIN;

	logic signed [SCORE_WIDTH:0]   wide;
	logic signed [SCORE_WIDTH-1:0] best_q;
	logic [IW-1:0]                 arg_q;

	// minus infinity absorbs, otherwise saturate
	always_comb begin
		wide = {a[SCORE_WIDTH-1], a} + {b[SCORE_WIDTH-1], b};
		if (a == SMIN || b == SMIN) begin
			sum = SMIN;
		end else if (wide[SCORE_WIDTH] != wide[SCORE_WIDTH-1]) begin
			sum = wide[SCORE_WIDTH] ? SMIN : SMAX;
		end else begin
			sum = wide[SCORE_WIDTH-1:0];
		end
	end

	// strict greater: first maximum wins
	always_ff @(posedge clk) begin
		case (op)
			ACU_FIRST: begin
				best_q <= sum;
				arg_q  <= idx;
			end
			ACU_CMP: begin
				if (sum > best_q) begin
					best_q <= sum;
					arg_q  <= idx;
				end
			end
			default: ;
		endcase
	end

	assign best = best_q;
	assign arg  = arg_q;

endmodule

// ===== sv/hmm_viterbi_decoder_core.sv =====
// Top level of the log-domain Viterbi decoder: sequencer, tables and traceback store.
// Beat to next beat: a load beat never raises busy; column 0 emission runs COL0 then CLOSE;
// a later emission takes one predecessor per cycle through the shared add-compare unit, and a
// dropped overflow column goes straight to CLOSE. Closing a stored column copies all MAX_STATES
// scores; the final beat then runs argmax, then one result per traceback read. No stalls.
// Reset clears control, column count and overflow and sets num_states to 8; tables undefined.
module hmm_viterbi_decoder_core import hvd_pkg::*; #(
	parameter int MAX_STATES  = DEF_MAX_STATES,
	parameter int MAX_LEN     = DEF_MAX_LEN,
	parameter int SCORE_WIDTH = DEF_SCORE_WIDTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  in_beat_t   item,
	input  logic       cfg_wr_en,
	input  logic [3:0] cfg_wr_data,
	output logic       result_valid,
	output out_beat_t  result
);

	localparam int IW  = $clog2(MAX_STATES);
	localparam int TAW = $clog2(MAX_STATES * MAX_STATES);
	localparam int TBW = $clog2(MAX_LEN * MAX_STATES);
	localparam int CW  = $clog2(MAX_LEN + 1);
	localparam int WW  = ((SCORE_WIDTH > 32) ? SCORE_WIDTH : 32) + 1;

	localparam logic signed [SCORE_WIDTH-1:0] SMIN = {1'b1, {(SCORE_WIDTH-1){1'b0}}};
	localparam logic signed [SCORE_WIDTH-1:0] SMAX = ~SMIN;
	localparam logic signed [WW-1:0] SMAX_W = {{(WW-SCORE_WIDTH+1){1'b0}}, {(SCORE_WIDTH-1){1'b1}}};
	localparam logic signed [WW-1:0] SMIN_W = ~SMAX_W;
	localparam logic signed [WW-1:0] I32MAX_W = {{(WW-31){1'b0}}, {31{1'b1}}};
	localparam logic signed [WW-1:0] I32MIN_W = ~I32MAX_W;
	localparam logic signed [31:0] I32MIN = 32'sh8000_0000;

	function automatic logic signed [SCORE_WIDTH-1:0] from_in(input logic signed [31:0] v);
		logic signed [WW-1:0] vw;
		vw = WW'(v);
		if (v == I32MIN) begin
			return SMIN;
		end else if (vw > SMAX_W) begin
			return SMAX;
		end else if (vw < SMIN_W) begin
			return SMIN;
		end
		return SCORE_WIDTH'(vw);
	endfunction

	function automatic logic signed [31:0] to_out(input logic signed [SCORE_WIDTH-1:0] v);
		logic signed [WW-1:0] vw;
		vw = WW'(v);
		if (v == SMIN || vw < I32MIN_W) begin
			return I32MIN;
		end else if (vw > I32MAX_W) begin
			return 32'(I32MAX_W);
		end
		return 32'(vw);
	endfunction

	// storage
	logic signed [SCORE_WIDTH-1:0] trans_mem [MAX_STATES*MAX_STATES];
	logic signed [SCORE_WIDTH-1:0] init_mem  [MAX_STATES];
	logic signed [SCORE_WIDTH-1:0] prev_mem  [MAX_STATES];
	logic signed [SCORE_WIDTH-1:0] next_mem  [MAX_STATES];
	logic [IW-1:0]                 tb_mem    [MAX_LEN*MAX_STATES];

	logic signed [SCORE_WIDTH-1:0] trans_rd, init_rd, prev_rd, next_rd;
	logic [IW-1:0]                 tb_rd;

	hvd_state_t state_q, state_d;

	logic [3:0]                    num_states_q;
	logic [CW-1:0]                 cc_q;
	logic                          ovf_q;
	logic [IW-1:0]                 j_q;
	logic                          rd_vld_s1;
	logic [IW-1:0]                 rd_idx_s1;
	logic [IW-1:0]                 to_q;
	logic signed [SCORE_WIDTH-1:0] val_q;
	logic                          last_q;
	logic [IW-1:0]                 s_q;
	logic [CW-1:0]                 t_q;
	logic signed [31:0]            score_q;

	logic                          accept;
	logic [IW-1:0]                 ns_last;
	logic                          emit_ok;
	logic                          trans_we, init_we, next_we, prev_we, tb_we;
	logic [TAW-1:0]                trans_waddr, trans_raddr;
	logic [TBW-1:0]                tb_waddr, tb_raddr;
	acu_op_t                       acu_op;
	logic signed [SCORE_WIDTH-1:0] acu_a, acu_b, acu_sum, acu_best;
	logic [IW-1:0]                 acu_arg;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	always_comb begin
		if (num_states_q == 4'd0) begin
			ns_last = '0;
		end else if (int'(num_states_q) > MAX_STATES) begin
			ns_last = IW'(MAX_STATES - 1);
		end else begin
			ns_last = IW'(int'(num_states_q) - 1);
		end
	end

	assign emit_ok = (item.mode == MODE_EMIT) && (int'(item.to_state) <= int'(ns_last));

	assign trans_we = accept && (item.mode == MODE_TRANS) &&
		(int'(item.from_state) < MAX_STATES) && (int'(item.to_state) < MAX_STATES);
	assign init_we  = accept && (item.mode == MODE_INIT) && (int'(item.to_state) < MAX_STATES);

	assign trans_waddr = TAW'(int'(item.from_state) * MAX_STATES + int'(item.to_state));
	assign trans_raddr = TAW'(int'(j_q) * MAX_STATES + int'(to_q));
	assign tb_waddr    = TBW'(int'(cc_q) * MAX_STATES + int'(to_q));
	assign tb_raddr    = TBW'(int'(t_q) * MAX_STATES + int'(s_q));

	always_ff @(posedge clk) begin
		if (trans_we) begin
			trans_mem[trans_waddr] <= from_in(item.value);
		end
		trans_rd <= trans_mem[trans_raddr];
	end

	always_ff @(posedge clk) begin
		if (init_we) begin
			init_mem[IW'(item.to_state)] <= from_in(item.value);
		end
		init_rd <= init_mem[IW'(item.to_state)];
	end

	always_ff @(posedge clk) begin
		if (next_we) begin
			next_mem[to_q] <= acu_sum;
		end
		next_rd <= next_mem[j_q];
	end

	always_ff @(posedge clk) begin
		if (prev_we) begin
			prev_mem[rd_idx_s1] <= next_rd;
		end
		prev_rd <= prev_mem[j_q];
	end

	always_ff @(posedge clk) begin
		if (tb_we) begin
			tb_mem[tb_waddr] <= acu_arg;
		end
		tb_rd <= tb_mem[tb_raddr];
	end

	hvd_acu #(
		.SCORE_WIDTH(SCORE_WIDTH),
		.MAX_STATES (MAX_STATES)
	) u_acu (
		.clk (clk),
		.op  (acu_op),
		.idx (rd_idx_s1),
		.a   (acu_a),
		.b   (acu_b),
		.sum (acu_sum),
		.best(acu_best),
		.arg (acu_arg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		next_we = 1'b0;
		prev_we = 1'b0;
		tb_we   = 1'b0;
		acu_op  = ACU_IDLE;
		acu_a   = prev_rd;
		acu_b   = trans_rd;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && emit_ok) begin
					if (cc_q == '0) begin
						state_d = ST_COL0;
					end else if (int'(cc_q) < MAX_LEN) begin
						state_d = ST_ACS;
					end else begin
						state_d = ST_CLOSE;
					end
				end
			end
			ST_COL0: begin
				acu_a   = init_rd;
				acu_b   = val_q;
				next_we = 1'b1;
				state_d = ST_CLOSE;
			end
			ST_ACS, ST_ACS_END: begin
				if (rd_vld_s1) begin
					acu_op = (rd_idx_s1 == '0) ? ACU_FIRST : ACU_CMP;
				end
				if (state_q == ST_ACS_END) begin
					state_d = ST_ADDV;
				end else if (j_q == ns_last) begin
					state_d = ST_ACS_END;
				end
			end
			ST_ADDV: begin
				acu_a   = acu_best;
				acu_b   = val_q;
				next_we = 1'b1;
				tb_we   = 1'b1;
				state_d = ST_CLOSE;
			end
			ST_CLOSE: begin
				if (to_q != ns_last) begin
					state_d = ST_IDLE;
				end else if (int'(cc_q) < MAX_LEN) begin
					state_d = ST_COPY;
				end else if (last_q) begin
					state_d = ST_ARG;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_COPY, ST_COPY_END: begin
				prev_we = rd_vld_s1;
				if (state_q == ST_COPY_END) begin
					state_d = last_q ? ST_ARG : ST_IDLE;
				end else if (int'(j_q) == MAX_STATES - 1) begin
					state_d = ST_COPY_END;
				end
			end
			ST_ARG, ST_ARG_END: begin
				acu_b = '0;
				if (rd_vld_s1) begin
					acu_op = (rd_idx_s1 == '0) ? ACU_FIRST : ACU_CMP;
				end
				if (state_q == ST_ARG_END) begin
					state_d = ST_TB_START;
				end else if (j_q == ns_last) begin
					state_d = ST_ARG_END;
				end
			end
			ST_TB_START: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				state_d = (t_q == '0) ? ST_IDLE : ST_TB_WAIT;
			end
			ST_TB_WAIT: begin
				state_d = ST_EMIT;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_states_q <= NUM_STATES_RST;
			cc_q         <= '0;
			ovf_q        <= 1'b0;
			j_q          <= '0;
			rd_vld_s1    <= 1'b0;
			t_q          <= '0;
		end else begin
			if (cfg_wr_en) begin
				num_states_q <= cfg_wr_data;
			end
			rd_vld_s1 <= (state_q == ST_ACS) || (state_q == ST_COPY) || (state_q == ST_ARG);
			if (state_q == ST_ACS || state_q == ST_COPY || state_q == ST_ARG) begin
				j_q <= j_q + 1'b1;
			end else begin
				j_q <= '0;
			end
			if (state_q == ST_CLOSE && to_q == ns_last && int'(cc_q) >= MAX_LEN) begin
				ovf_q <= 1'b1;
			end
			if (state_q == ST_COPY_END) begin
				cc_q <= cc_q + 1'b1;
			end
			if (state_q == ST_TB_START) begin
				t_q <= cc_q - 1'b1;
			end else if (state_q == ST_EMIT) begin
				if (t_q == '0) begin
					cc_q  <= '0;
					ovf_q <= 1'b0;
				end else begin
					t_q <= t_q - 1'b1;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rd_idx_s1 <= j_q;
		if (accept) begin
			to_q   <= IW'(item.to_state);
			val_q  <= from_in(item.value);
			last_q <= item.last_obs;
		end
		if (state_q == ST_TB_START) begin
			score_q <= to_out(acu_best);
			s_q     <= acu_arg;
		end else if (state_q == ST_TB_WAIT) begin
			s_q <= tb_rd;
		end
	end

	assign result_valid      = (state_q == ST_EMIT);
	assign result.path_state = 3'(s_q);
	assign result.time_index = 6'(t_q);
	assign result.best_score = score_q;
	assign result.overflow   = ovf_q;
	assign result.last       = (t_q == '0);

endmodule

// ===== sv/hvd_chk.sv =====
// Port-level checker for the Viterbi decoder and its bind to the top level.
`include "hmm_viterbi_decoder_core_defines.svh"

module hvd_chk import hvd_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input in_beat_t  item,
	input logic      result_valid,
	input out_beat_t result
);

	`HVD_ASSERT_NOW(a_result_while_busy, result_valid, busy, "result beat while not busy")
	`HVD_ASSERT_NEXT(a_last_ends_run, result_valid && result.last, !busy, "busy after last beat")
	`HVD_ASSERT_NEXT(a_load_no_busy, start && !busy && item.mode != MODE_EMIT, !busy, "load beat held block busy")
	`HVD_ASSERT_LATER2(a_path_steps, result_valid && !result.last, result_valid && (result.time_index == $past(result.time_index, 2) - 6'd1), "time index did not step down")
	`HVD_ASSERT_LATER2(a_run_const, result_valid && !result.last, (result.best_score == $past(result.best_score, 2)) && (result.overflow == $past(result.overflow, 2)), "score or overflow changed within a run")

endmodule

bind hmm_viterbi_decoder_core hvd_chk u_hvd_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.item        (item),
	.result_valid(result_valid),
	.result      (result)
);
